@@ design/rmh_pkg.sv @@
`default_nettype none
package rmh_pkg;

    localparam int VALUE_W    = 32;
    localparam int CAPACITY   = 1024;
    localparam int HEAP_DEPTH = CAPACITY / 2 + 1;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = ADDR_W;
    localparam int TOTAL_W    = 11;
    localparam int MED_W      = VALUE_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PUSH_INIT,
        ST_PUSH_RD,
        ST_PUSH_CMP,
        ST_REBAL,
        ST_POP_INIT,
        ST_POP_LAST,
        ST_POP_RDL,
        ST_POP_RDR,
        ST_POP_CMP,
        ST_MOVE,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PUSH_INIT,
        OP_PUSH_RD,
        OP_PUSH_CMP,
        OP_POP_INIT,
        OP_POP_LAST,
        OP_POP_RDL,
        OP_POP_RDR,
        OP_POP_CMP,
        OP_MOVE,
        OP_OUT
    } op_t;

    // sel: 0 = lower (max) heap, 1 = upper (min) heap
    typedef struct packed {
        op_t  op;
        logic sel;
        logic dropped;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic go_lower;
        logic lo2up;
        logic up2lo;
        logic push_root;
        logic push_up;
        logic pop_leaf;
        logic pop_stay;
    } dp_stat_t;

endpackage
`default_nettype wire

@@ design/running_median_two_heaps.sv @@
// Channel | Ports                                         | Direction
// s_      | s_valid, s_ready, s_sample                    | request in
// m_      | m_valid, m_ready, m_median_doubled,
//         | m_stored_count, m_dropped                     | request out
//
// Steps: a request pushes the sample into one heap with a sift-up; a rebalance
// then pops the top of the larger heap with a sift-down and pushes that moved
// top into the other heap with a sift-up. Each heap memory has a single read
// port. A request at a full store skips the heaps and is flagged as dropped.
// Reset clears counts and control; heap memories need no clearing.
// A new request is taken while the previous result waits in the output register.
`default_nettype none
module running_median_two_heaps
    import rmh_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [VALUE_W-1:0]  s_sample,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [MED_W-1:0]         m_median_doubled,
    output logic [TOTAL_W-1:0]              m_stored_count,
    output logic                            m_dropped
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rmh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rmh_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_sample         (s_sample),
        .m_median_doubled (m_median_doubled),
        .m_stored_count   (m_stored_count),
        .m_dropped        (m_dropped)
    );

endmodule
`default_nettype wire

@@ design/rmh_datapath.sv @@
`default_nettype none
module rmh_datapath
    import rmh_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire dp_cmd_t                    cmd,
    output dp_stat_t                        stat,
    input  wire logic signed [VALUE_W-1:0]  s_sample,
    output logic signed [MED_W-1:0]         m_median_doubled,
    output logic [TOTAL_W-1:0]              m_stored_count,
    output logic                            m_dropped
);

    logic signed [VALUE_W-1:0] mem_lo [HEAP_DEPTH];
    logic signed [VALUE_W-1:0] mem_up [HEAP_DEPTH];

    logic signed [VALUE_W-1:0] rd_lo_reg, rd_up_reg;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic signed [VALUE_W-1:0] carry_reg, carry_next;
    logic signed [VALUE_W-1:0] left_reg, left_next;
    logic signed [VALUE_W-1:0] top_lo_reg, top_up_reg;
    logic [ADDR_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]          lo_cnt_reg, lo_cnt_next, up_cnt_reg, up_cnt_next;
    logic signed [MED_W-1:0]   med_reg;
    logic [TOTAL_W-1:0]        cnt_out_reg;
    logic                      drop_reg;

    logic [ADDR_W-1:0]         raddr, waddr, parent;
    logic signed [VALUE_W-1:0] wdata, rdata, top_sel, pick_v;
    logic                      we;
    logic [CNT_W-1:0]          cnt_sel;
    logic [ADDR_W:0]           lchild, rchild;
    logic                      pick_l, pick_r;
    logic [TOTAL_W-1:0]        total;

    function automatic logic above(input logic signed [VALUE_W-1:0] a,
                                   input logic signed [VALUE_W-1:0] b,
                                   input logic is_min);
        return is_min ? (a < b) : (a > b);
    endfunction

    assign cnt_sel = cmd.sel ? up_cnt_reg : lo_cnt_reg;
    assign rdata   = cmd.sel ? rd_up_reg : rd_lo_reg;
    assign top_sel = cmd.sel ? top_up_reg : top_lo_reg;
    assign parent  = (idx_reg - ADDR_W'(1)) >> 1;
    assign lchild  = {idx_reg, 1'b1};
    assign rchild  = lchild + (ADDR_W+1)'(1);
    assign total   = TOTAL_W'(lo_cnt_reg) + TOTAL_W'(up_cnt_reg);

    // child selection during sift-down
    always_comb begin
        pick_l = above(left_reg, val_reg, cmd.sel);
        pick_v = pick_l ? left_reg : val_reg;
        pick_r = (rchild < (ADDR_W+1)'(cnt_sel)) && above(rdata, pick_v, cmd.sel);
    end

    // status to controller
    always_comb begin
        stat.full      = total >= TOTAL_W'(CAPACITY);
        stat.go_lower  = (lo_cnt_reg == '0) || (val_reg < top_lo_reg);
        stat.lo2up     = (CNT_W+1)'(lo_cnt_reg) > (CNT_W+1)'(up_cnt_reg) + (CNT_W+1)'(1);
        stat.up2lo     = up_cnt_reg > lo_cnt_reg;
        stat.push_root = idx_reg == '0;
        stat.push_up   = above(val_reg, rdata, cmd.sel);
        stat.pop_leaf  = lchild >= (ADDR_W+1)'(cnt_sel);
        stat.pop_stay  = !pick_l && !pick_r;
    end

    // per-operation next values
    always_comb begin
        val_next    = val_reg;
        carry_next  = carry_reg;
        left_next   = left_reg;
        idx_next    = idx_reg;
        lo_cnt_next = lo_cnt_reg;
        up_cnt_next = up_cnt_reg;
        raddr       = '0;
        waddr       = idx_reg;
        wdata       = val_reg;
        we          = 1'b0;
        case (cmd.op)
            OP_LOAD: val_next = s_sample;
            OP_PUSH_INIT: begin
                idx_next = cnt_sel;
                if (cmd.sel) up_cnt_next = up_cnt_reg + CNT_W'(1);
                else         lo_cnt_next = lo_cnt_reg + CNT_W'(1);
            end
            OP_PUSH_RD: begin
                if (idx_reg == '0) we = 1'b1;
                else raddr = parent;
            end
            OP_PUSH_CMP: begin
                we = 1'b1;
                if (above(val_reg, rdata, cmd.sel)) begin
                    wdata    = rdata;
                    idx_next = parent;
                end
            end
            OP_POP_INIT: begin
                carry_next = top_sel;
                raddr      = cnt_sel - CNT_W'(1);
                if (cmd.sel) up_cnt_next = up_cnt_reg - CNT_W'(1);
                else         lo_cnt_next = lo_cnt_reg - CNT_W'(1);
            end
            OP_POP_LAST: begin
                val_next = rdata;
                idx_next = '0;
            end
            OP_POP_RDL: begin
                if (lchild >= (ADDR_W+1)'(cnt_sel)) we = 1'b1;
                else raddr = lchild[ADDR_W-1:0];
            end
            OP_POP_RDR: begin
                left_next = rdata;
                raddr     = rchild[ADDR_W-1:0];
            end
            OP_POP_CMP: begin
                we = 1'b1;
                if (pick_r) begin
                    wdata    = rdata;
                    idx_next = rchild[ADDR_W-1:0];
                end else if (pick_l) begin
                    wdata    = left_reg;
                    idx_next = lchild[ADDR_W-1:0];
                end
            end
            OP_MOVE: val_next = carry_reg;
            default: ;
        endcase
    end

    // heap stores, registered read
    always_ff @(posedge aclk) begin
        if (we && !cmd.sel) mem_lo[waddr] <= wdata;
        if (we && cmd.sel)  mem_up[waddr] <= wdata;
        rd_lo_reg <= mem_lo[raddr];
        rd_up_reg <= mem_up[raddr];
    end

    // working registers; tops mirror entry 0
    always_ff @(posedge aclk) begin
        val_reg   <= val_next;
        carry_reg <= carry_next;
        left_reg  <= left_next;
        idx_reg   <= idx_next;
        if (we && waddr == '0 && !cmd.sel) top_lo_reg <= wdata;
        if (we && waddr == '0 && cmd.sel)  top_up_reg <= wdata;
        if (cmd.op == OP_OUT) begin
            if (lo_cnt_reg == '0)
                med_reg <= '0;
            else if (lo_cnt_reg == up_cnt_reg)
                med_reg <= MED_W'(top_lo_reg) + MED_W'(top_up_reg);
            else
                med_reg <= {top_lo_reg, 1'b0};
            cnt_out_reg <= total;
            drop_reg    <= cmd.dropped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_cnt_reg <= '0;
            up_cnt_reg <= '0;
        end else begin
            lo_cnt_reg <= lo_cnt_next;
            up_cnt_reg <= up_cnt_next;
        end
    end

    assign m_median_doubled = med_reg;
    assign m_stored_count   = cnt_out_reg;
    assign m_dropped        = drop_reg;

endmodule
`default_nettype wire

@@ design/rmh_ctrl.sv @@
`default_nettype none
module rmh_ctrl
    import rmh_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   sel_reg, sel_next;
    logic   phase_reg, phase_next;   // 1 while pushing the moved top
    logic   drop_reg, drop_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        phase_next = phase_reg;
        drop_next  = drop_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_DECIDE;
            ST_DECIDE: begin
                drop_next  = stat.full;
                sel_next   = !stat.go_lower;
                phase_next = 1'b0;
                state_next = stat.full ? ST_DONE : ST_PUSH_INIT;
            end
            ST_PUSH_INIT: state_next = ST_PUSH_RD;
            ST_PUSH_RD: begin
                if (stat.push_root) state_next = phase_reg ? ST_DONE : ST_REBAL;
                else                state_next = ST_PUSH_CMP;
            end
            ST_PUSH_CMP: begin
                if (stat.push_up) state_next = ST_PUSH_RD;
                else              state_next = phase_reg ? ST_DONE : ST_REBAL;
            end
            ST_REBAL: begin
                if (stat.lo2up) begin
                    sel_next   = 1'b0;
                    state_next = ST_POP_INIT;
                end else if (stat.up2lo) begin
                    sel_next   = 1'b1;
                    state_next = ST_POP_INIT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_POP_INIT: state_next = ST_POP_LAST;
            ST_POP_LAST: state_next = ST_POP_RDL;
            ST_POP_RDL:  state_next = stat.pop_leaf ? ST_MOVE : ST_POP_RDR;
            ST_POP_RDR:  state_next = ST_POP_CMP;
            ST_POP_CMP:  state_next = stat.pop_stay ? ST_MOVE : ST_POP_RDL;
            ST_MOVE: begin
                sel_next   = !sel_reg;
                phase_next = 1'b1;
                state_next = ST_PUSH_INIT;
            end
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd.op       = OP_NONE;
        cmd.sel      = sel_reg;
        cmd.dropped  = drop_reg;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = OP_LOAD;
            end
            ST_PUSH_INIT: cmd.op = OP_PUSH_INIT;
            ST_PUSH_RD:   cmd.op = OP_PUSH_RD;
            ST_PUSH_CMP:  cmd.op = OP_PUSH_CMP;
            ST_POP_INIT:  cmd.op = OP_POP_INIT;
            ST_POP_LAST:  cmd.op = OP_POP_LAST;
            ST_POP_RDL:   cmd.op = OP_POP_RDL;
            ST_POP_RDR:   cmd.op = OP_POP_RDR;
            ST_POP_CMP:   cmd.op = OP_POP_CMP;
            ST_MOVE:      cmd.op = OP_MOVE;
            ST_DONE: begin
                if (out_free) begin
                    cmd.op       = OP_OUT;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sel_reg     <= 1'b0;
            phase_reg   <= 1'b0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            phase_reg   <= phase_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

@@ tb/running_median_two_heaps_tb.sv @@
`default_nettype none
module running_median_two_heaps_tb
    import rmh_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    // expected result of one request
    typedef struct {
        logic signed [MED_W-1:0] median;
        logic [TOTAL_W-1:0]      count;
        logic                    dropped;
    } median_result_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [VALUE_W-1:0] s_sample = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [MED_W-1:0]   m_median_doubled;
    logic [TOTAL_W-1:0]        m_stored_count;
    logic                      m_dropped;

    running_median_two_heaps u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_median_doubled(m_median_doubled),
        .m_stored_count(m_stored_count), .m_dropped(m_dropped)
    );

    always #6 aclk = ~aclk;

    // predictor state: two heaps kept as binary heaps in plain arrays
    logic signed [VALUE_W-1:0] lo_heap [HEAP_DEPTH];
    logic signed [VALUE_W-1:0] hi_heap [HEAP_DEPTH];
    int unsigned lo_cnt = 0, hi_cnt = 0;

    logic signed [VALUE_W-1:0] sample_q [$];
    median_result_t            median_q [$];
    bit                        stim_done = 0;
    bit                        hold_off = 0;
    bit                        no_idle = 0;
    int                        mismatches = 0;
    int                        results_seen = 0;
    int                        drops_seen = 0;
    int                        idle_cycles = 0;

    function automatic bit ranks(logic signed [VALUE_W-1:0] a,
                                 logic signed [VALUE_W-1:0] b, bit is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic heap_insert(bit is_max, logic signed [VALUE_W-1:0] v);
        int unsigned i, p;
        logic signed [VALUE_W-1:0] t;
        if (is_max) begin
            i = lo_cnt; lo_heap[i] = v; lo_cnt++;
            while (i > 0) begin
                p = (i - 1) / 2;
                if (!ranks(lo_heap[i], lo_heap[p], 1)) break;
                t = lo_heap[i]; lo_heap[i] = lo_heap[p]; lo_heap[p] = t; i = p;
            end
        end else begin
            i = hi_cnt; hi_heap[i] = v; hi_cnt++;
            while (i > 0) begin
                p = (i - 1) / 2;
                if (!ranks(hi_heap[i], hi_heap[p], 0)) break;
                t = hi_heap[i]; hi_heap[i] = hi_heap[p]; hi_heap[p] = t; i = p;
            end
        end
    endtask

    task automatic heap_remove_top(bit is_max, output logic signed [VALUE_W-1:0] top);
        int unsigned n, i, l, r, best;
        logic signed [VALUE_W-1:0] t;
        if (is_max) begin
            top = lo_heap[0]; lo_cnt--; n = lo_cnt; lo_heap[0] = lo_heap[n];
        end else begin
            top = hi_heap[0]; hi_cnt--; n = hi_cnt; hi_heap[0] = hi_heap[n];
        end
        i = 0;
        forever begin
            l = 2 * i + 1; r = l + 1; best = i;
            if (is_max) begin
                if (l < n && ranks(lo_heap[l], lo_heap[best], 1)) best = l;
                if (r < n && ranks(lo_heap[r], lo_heap[best], 1)) best = r;
                if (best == i) break;
                t = lo_heap[i]; lo_heap[i] = lo_heap[best]; lo_heap[best] = t;
            end else begin
                if (l < n && ranks(hi_heap[l], hi_heap[best], 0)) best = l;
                if (r < n && ranks(hi_heap[r], hi_heap[best], 0)) best = r;
                if (best == i) break;
                t = hi_heap[i]; hi_heap[i] = hi_heap[best]; hi_heap[best] = t;
            end
            i = best;
        end
    endtask

    // work out the result for one accepted sample
    task automatic predict_median(logic signed [VALUE_W-1:0] v);
        median_result_t r;
        logic signed [VALUE_W-1:0] t;
        r.dropped = 1'b0;
        if (lo_cnt + hi_cnt >= CAPACITY) begin
            r.dropped = 1'b1;
        end else begin
            if (lo_cnt == 0 || v < lo_heap[0]) heap_insert(1, v);
            else heap_insert(0, v);
            if (lo_cnt > hi_cnt + 1) begin
                heap_remove_top(1, t); heap_insert(0, t);
            end else if (hi_cnt > lo_cnt) begin
                heap_remove_top(0, t); heap_insert(1, t);
            end
        end
        r.count = TOTAL_W'(lo_cnt + hi_cnt);
        if (lo_cnt == 0) r.median = '0;
        else if (lo_cnt == hi_cnt)
            r.median = MED_W'(lo_heap[0]) + MED_W'(hi_heap[0]);
        else r.median = MED_W'(lo_heap[0]) <<< 1;
        median_q.push_back(r);
    endtask

    // driver: one pending sample at a time, random gaps
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_median(s_sample);
            end
            if (!s_valid || s_ready) begin
                if (sample_q.size() > 0 && !hold_off &&
                    (no_idle || $urandom_range(99) >= 20)) begin
                    s_valid  <= 1'b1;
                    s_sample <= sample_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare every result with the oldest expectation
    always @(posedge aclk) begin
        median_result_t e;
        if (aresetn) begin
            m_ready <= no_idle || ($urandom_range(99) >= 20);
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_dropped) drops_seen++;
                if (median_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result median=%0d count=%0d dropped=%0b",
                                 m_median_doubled, m_stored_count, m_dropped);
                end else begin
                    e = median_q.pop_front();
                    if (m_median_doubled !== e.median || m_stored_count !== e.count ||
                        m_dropped !== e.dropped) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp median=%0d count=%0d dropped=%0b,",
                                      " got median=%0d count=%0d dropped=%0b"},
                                     e.median, e.count, e.dropped,
                                     m_median_doubled, m_stored_count, m_dropped);
                    end
                end
            end
        end
    end

    // watchdog: cycles without any accepted request or taken result
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic signed [VALUE_W-1:0] rand_sample();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 32'sh7fffffff;
        if (k == 1) return 32'sh80000000;
        if (k < 4) return VALUE_W'($signed($urandom_range(15)) - 8);
        return $urandom;
    endfunction

    task automatic wait_drained();
        while (sample_q.size() > 0 || s_valid || median_q.size() > 0) @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, duplicates equal to the lower top, both signs
        sample_q.push_back(32'sh7fffffff);
        sample_q.push_back(32'sh80000000);
        sample_q.push_back(32'sh7fffffff);
        sample_q.push_back(32'sh80000000);
        sample_q.push_back(0);
        sample_q.push_back(0);
        sample_q.push_back(0);
        sample_q.push_back(-1);
        sample_q.push_back(1);
        sample_q.push_back(32'sh55555555);
        sample_q.push_back(32'shaaaaaaaa);
        sample_q.push_back(-1);
        sample_q.push_back(-1);
        wait_drained();

        // sender holds off while four samples queue up, then releases them
        hold_off = 1;
        for (int i = 0; i < 4; i++) sample_q.push_back(rand_sample());
        repeat (50) @(posedge aclk);
        hold_off = 0;
        wait_drained();

        // random fill past capacity so the full-store drop shows up
        for (int i = 0; i < 1300; i++) begin
            if (i == 300) no_idle = 1;
            if (i == 500) no_idle = 0;
            sample_q.push_back(rand_sample());
            while (sample_q.size() > 8) @(posedge aclk);
        end
        wait_drained();
        repeat (100) @(posedge aclk);

        $display("checked %0d results, %0d of them dropped at a full store",
                 results_seen, drops_seen);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
